// ===== design/zctps_pkg.sv =====
// ----------------------------------------------------------------------------
// zctps_pkg: shared definitions for the zero-cross timed pattern sequencer
// Command codes, register map, field widths and reset values used by the
// top level and by the pattern table.
// ----------------------------------------------------------------------------
`default_nettype none

package zctps_pkg;

  // Command codes carried by the cmd field of an input word.
  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_ZERO_CROSS = 2'd1;
  localparam logic [1:0] CMD_WRITE      = 2'd2;

  // Register map, as register indexes (byte address is four times the index).
  localparam logic REG_ZERO_CROSS_DELAY = 1'b0;

  // Fixed field widths.
  localparam int DELAY_W  = 16;
  localparam int PERIOD_W = 20;
  localparam int INDEX_W  = 5;

  // Register reset value and period counter ceiling.
  localparam logic [DELAY_W-1:0]  ZERO_CROSS_DELAY_RESET = 16'd70;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX             = 20'hFFFFF;

  // Default parameter values.
  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam int PIN_COUNT_DEFAULT   = 10;

endpackage

`default_nettype wire

// ===== design/zctps_table.sv =====
// ----------------------------------------------------------------------------
// zctps_table: double-banked pattern table
// One write port and one read port with a registered read. Each entry keeps
// a valid bit, cleared at reset, so an entry never written reads as pins
// zero, last set, delay zero. Entry layout is {last, delay, pins}.
// ----------------------------------------------------------------------------
`default_nettype none

module zctps_table
  import zctps_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int PIN_W = PIN_COUNT_DEFAULT,
  localparam int AW = $clog2(2 * DEPTH),
  localparam int EW = PIN_W + DELAY_W + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [EW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [EW-1:0] rd_data
);

  localparam logic [EW-1:0] ENTRY_RESET = {1'b1, {(EW-1){1'b0}}};

  logic [EW-1:0] mem [2*DEPTH];
  logic          valid [2*DEPTH];
  logic [EW-1:0] rd_q;
  logic          rd_ok;

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits, one per entry, and the valid flag of the last read.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2 * DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= valid[rd_addr];
      end
    end
  end

  // An entry never written reads as the reset pattern.
  assign rd_data = rd_ok ? rd_q : ENTRY_RESET;

endmodule

`default_nettype wire

// ===== design/zero_cross_timed_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// zero_cross_timed_pattern_sequencer_top: phase-angle trigger sequencer
// Drives trigger pins from a double-buffered pattern table, started a set
// delay after each zero-cross event and stepped by microsecond ticks.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                   Direction  Word
//  -------  ----------------------------------------  ---------  -------------------
//  input    in_valid/in_ready, cmd, entry_*           in         tick, zero-cross, write
//  output   out_valid/out_ready, pin_levels, ...      out        one word per input
//  config   psel/penable/pwrite/paddr/pwdata/prdata   in/out     zero_cross_delay
//
//  A new input word is accepted in every cycle in which the output register
//  is empty or is being emptied.
//  The next pattern entry is prefetched from the table memory when an entry
//  is applied, so it is ready in the next cycle; entry 0 of each bank is kept
//  in a register copy for the period start.
//  Reset clears all control state at once; no clearing pass is needed.
//  A stall on the output holds in_ready low and freezes all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_cross_timed_pattern_sequencer_top
  import zctps_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int PIN_COUNT   = PIN_COUNT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           cmd,
  input  wire logic [INDEX_W-1:0]   entry_index,
  input  wire logic [PIN_COUNT-1:0] entry_pins,
  input  wire logic                 entry_last,
  input  wire logic [DELAY_W-1:0]   entry_delay,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIN_COUNT-1:0]      pin_levels,
  output logic                      period_started,
  output logic [PERIOD_W-1:0]       period_length,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int AW = $clog2(2 * TABLE_DEPTH);
  localparam int EW = PIN_COUNT + DELAY_W + 1;
  localparam logic [EW-1:0] ENTRY_RESET = {1'b1, {(EW-1){1'b0}}};
  localparam logic [IW-1:0] LAST_INDEX  = IW'(TABLE_DEPTH - 1);

  // State registers.
  logic [DELAY_W-1:0]   zero_cross_delay;
  logic                 active_bank, active_bank_next;
  logic [IW-1:0]        step_index, step_index_next;
  logic [DELAY_W-1:0]   step_countdown, step_countdown_next;
  logic                 step_running, step_running_next;
  logic [DELAY_W-1:0]   delay_countdown, delay_countdown_next;
  logic                 delay_running, delay_running_next;
  logic [PERIOD_W-1:0]  tick_count, tick_count_next;
  logic [PERIOD_W-1:0]  measured_period, measured_period_next;
  logic [PIN_COUNT-1:0] pin_register, pin_register_next;
  logic                 started, started_next;
  logic [EW-1:0]        entry0 [2];

  // Table access signals.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  // Decode helpers.
  logic                 accept;
  logic                 is_tick, is_zc, is_write;
  logic                 write_in_range;
  logic [IW-1:0]        wr_idx;
  logic                 prep_bank;
  logic [DELAY_W-1:0]   step_dec, delay_dec;
  logic                 step_fire, zc_fire, apply_go;
  logic [EW-1:0]        app_entry;
  logic [IW-1:0]        app_idx, app_idx_inc;
  logic                 app_bank, app_last;
  logic [DELAY_W-1:0]   app_delay;

  function automatic logic [AW-1:0] table_addr(input logic bank, input logic [IW-1:0] idx);
    table_addr = bank ? AW'(TABLE_DEPTH) + AW'(idx) : AW'(idx);
  endfunction

  // Handshake: the output register parts the two sides.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_tick  = accept && (cmd == CMD_TICK);
  assign is_zc    = accept && (cmd == CMD_ZERO_CROSS);
  assign is_write = accept && (cmd == CMD_WRITE);

  // Writes go to the preparing bank, ignoring indexes past the table.
  assign prep_bank      = ~active_bank;
  assign write_in_range = 32'(entry_index) < 32'(TABLE_DEPTH);
  assign wr_idx         = IW'(entry_index);
  assign wr_en          = is_write && write_in_range;
  assign wr_addr        = table_addr(prep_bank, wr_idx);
  assign wr_data        = {entry_last, entry_delay, entry_pins};

  // Countdowns for this tick; a period start overrides a step.
  assign step_dec  = (step_countdown != '0) ? step_countdown - DELAY_W'(1) : '0;
  assign delay_dec = (delay_countdown != '0) ? delay_countdown - DELAY_W'(1) : '0;
  assign step_fire = step_running && (step_dec == '0);
  assign zc_fire   = delay_running && (delay_dec == '0);
  assign apply_go  = is_tick && (step_fire || zc_fire);

  // Entry to apply: entry 0 of the new bank, or the prefetched next entry.
  assign app_entry   = zc_fire ? entry0[prep_bank] : rd_data;
  assign app_idx     = zc_fire ? '0 : step_index;
  assign app_bank    = zc_fire ? prep_bank : active_bank;
  assign app_last    = app_entry[EW-1] || (app_idx == LAST_INDEX);
  assign app_delay   = app_entry[PIN_COUNT +: DELAY_W];
  assign app_idx_inc = app_idx + IW'(1);

  // Prefetch the following entry whenever stepping continues.
  assign rd_en   = apply_go && !app_last;
  assign rd_addr = table_addr(app_bank, app_idx_inc);

  // Next-state logic for one input word.
  always_comb begin
    active_bank_next     = active_bank;
    step_index_next      = step_index;
    step_countdown_next  = step_countdown;
    step_running_next    = step_running;
    delay_countdown_next = delay_countdown;
    delay_running_next   = delay_running;
    tick_count_next      = tick_count;
    measured_period_next = measured_period;
    pin_register_next    = pin_register;
    started_next         = started;

    if (accept) begin
      started_next = 1'b0;
    end

    if (is_tick) begin
      tick_count_next = (tick_count == PERIOD_MAX) ? tick_count : tick_count + PERIOD_W'(1);
      if (step_running) begin
        step_countdown_next = step_dec;
      end
      if (delay_running) begin
        delay_countdown_next = delay_dec;
      end
      if (zc_fire) begin
        delay_running_next   = 1'b0;
        measured_period_next = tick_count_next;
        tick_count_next      = '0;
        active_bank_next     = prep_bank;
        started_next         = 1'b1;
      end
      if (apply_go) begin
        pin_register_next = app_entry[PIN_COUNT-1:0];
        if (app_last) begin
          step_index_next     = '0;
          step_running_next   = 1'b0;
          step_countdown_next = '0;
        end else begin
          step_index_next     = app_idx_inc;
          step_running_next   = 1'b1;
          step_countdown_next = (app_delay != '0) ? app_delay : DELAY_W'(1);
        end
      end
    end else if (is_zc) begin
      delay_countdown_next = (zero_cross_delay != '0) ? zero_cross_delay : DELAY_W'(1);
      delay_running_next   = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank     <= 1'b1;
      step_index      <= '0;
      step_countdown  <= '0;
      step_running    <= 1'b0;
      delay_countdown <= '0;
      delay_running   <= 1'b0;
      tick_count      <= '0;
      measured_period <= '0;
      pin_register    <= '0;
      started         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      active_bank     <= active_bank_next;
      step_index      <= step_index_next;
      step_countdown  <= step_countdown_next;
      step_running    <= step_running_next;
      delay_countdown <= delay_countdown_next;
      delay_running   <= delay_running_next;
      tick_count      <= tick_count_next;
      measured_period <= measured_period_next;
      pin_register    <= pin_register_next;
      started         <= started_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Register copy of entry 0 in each bank, kept in step with table writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry0[0] <= ENTRY_RESET;
      entry0[1] <= ENTRY_RESET;
    end else if (wr_en && (wr_idx == '0)) begin
      entry0[prep_bank] <= wr_data;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_cross_delay <= ZERO_CROSS_DELAY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ZERO_CROSS_DELAY)) begin
      zero_cross_delay <= pwdata[DELAY_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ZERO_CROSS_DELAY) ? 32'(zero_cross_delay) : '0;

  // Result word comes straight from the state it reports.
  assign pin_levels     = pin_register;
  assign period_started = started;
  assign period_length  = measured_period;

  // Pattern table memory.
  zctps_table #(
    .DEPTH (TABLE_DEPTH),
    .PIN_W (PIN_COUNT)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
